// File: sv/ordered_list_append_remove_assert.svh
// Assertion macros used by the ordered list datapath.
// Each macro expects clk and arst_n to be visible in the module that uses it.
`ifndef ORDERED_LIST_APPEND_REMOVE_ASSERT_SVH
`define ORDERED_LIST_APPEND_REMOVE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OLA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("ordered list assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OLA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("ordered list assertion failed");

`endif

// File: sv/ola_pkg.sv
// ----------------------------------------------------------------------------
// ola_pkg
// Types and codes shared by the ordered list controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ola_pkg;

	localparam int VAL_W = 32;
	localparam int RC_W  = 5;

	// Action codes carried by an input transaction.
	typedef logic [1:0] action_t;
	localparam action_t ACT_APPEND = 2'd0;
	localparam action_t ACT_SHOW   = 2'd1;
	localparam action_t ACT_REMOVE = 2'd2;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_APPENDED  = 3'd0,
		ST_SHOWN     = 3'd1,
		ST_REMOVED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic do_append;
		logic emit_full;
		logic emit_empty;
		logic emit_not_found;
		logic scan_start;
		logic scan_remove;
		logic rd_en;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic is_empty;
		logic is_full;
		logic rd_last;
	} stat_t;

endpackage

`default_nettype wire

// File: sv/ola_ctrl.sv
// ----------------------------------------------------------------------------
// ola_ctrl
// Controller: accepts transactions and sequences the walk over stored entries.
// ----------------------------------------------------------------------------
`default_nettype none

module ola_ctrl
	import ola_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire action_t action,
	input  wire stat_t   stat,
	output cmd_t         cmd,
	output logic         busy
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = start && (state_q == S_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !stat.is_empty &&
				    (action == ACT_SHOW || action == ACT_REMOVE)) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.rd_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		cmd  = '0;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (action)
						ACT_APPEND: begin
							cmd.do_append = !stat.is_full;
							cmd.emit_full = stat.is_full;
						end
						ACT_SHOW: begin
							cmd.emit_empty = stat.is_empty;
							cmd.scan_start = !stat.is_empty;
						end
						ACT_REMOVE: begin
							cmd.emit_not_found = stat.is_empty;
							cmd.scan_start     = !stat.is_empty;
							cmd.scan_remove    = 1'b1;
						end
						default: begin
							cmd = '0;
						end
					endcase
				end
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
			end
			S_DRAIN: begin
				cmd = '0;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: sv/ola_dpath.sv
// ----------------------------------------------------------------------------
// ola_dpath
// Datapath: entry memory, count, read pointer, compaction and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_list_append_remove_assert.svh"

module ola_dpath
	import ola_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cmd_t                    cmd,
	input  wire logic signed [VAL_W-1:0] value,
	output stat_t                        stat,
	output logic                         done,
	output logic [2:0]                   status,
	output logic signed [VAL_W-1:0]      entry_value,
	output logic [RC_W-1:0]              removed_count,
	output logic                         last
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int RW = (CW > RC_W) ? CW : RC_W;

	logic signed [VAL_W-1:0] mem [CAPACITY];

	logic [CW-1:0]           count_q;
	logic [CW-1:0]           kept_q;
	logic [AW-1:0]           ptr_q;
	logic                    remove_q;
	logic signed [VAL_W-1:0] match_q;

	logic                    vld_s1;
	logic [AW-1:0]           idx_s1;
	logic signed [VAL_W-1:0] rdata_s1;

	logic                    done_q;
	status_t                 status_q;
	logic signed [VAL_W-1:0] entry_value_q;
	logic [RC_W-1:0]         removed_q;
	logic                    last_q;

	logic [CW-1:0]           cnt_m1;
	logic                    last_s1;
	logic                    keep_s1;
	logic [CW-1:0]           kept_nxt;
	logic [RW-1:0]           rem_w;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic signed [VAL_W-1:0] wr_data;

	// Status toward the controller.
	assign cnt_m1        = count_q - CW'(1);
	assign stat.is_empty = (count_q == '0);
	assign stat.is_full  = (count_q == CW'(CAPACITY));
	assign stat.rd_last  = (ptr_q == cnt_m1[AW-1:0]);

	// Compaction: keep entries that differ from the match value.
	assign last_s1  = (idx_s1 == cnt_m1[AW-1:0]);
	assign keep_s1  = (rdata_s1 != match_q);
	assign kept_nxt = kept_q + CW'(keep_s1);
	assign rem_w    = RW'(count_q) - RW'(kept_nxt);

	// Memory write port is shared by append and compaction.
	assign wr_en   = cmd.do_append || (vld_s1 && remove_q && keep_s1);
	assign wr_addr = cmd.do_append ? count_q[AW-1:0] : kept_q[AW-1:0];
	assign wr_data = cmd.do_append ? value : rdata_s1;

	// Entry memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[ptr_q];
			idx_s1   <= ptr_q;
		end
	end

	// Transaction context.
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			match_q  <= value;
			remove_q <= cmd.scan_remove;
		end
	end

	// Count, pointers and read-stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			kept_q  <= '0;
			ptr_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en;
			if (cmd.scan_start) begin
				ptr_q  <= '0;
				kept_q <= '0;
			end else if (cmd.rd_en) begin
				ptr_q <= ptr_q + AW'(1);
			end
			if (vld_s1 && remove_q) begin
				kept_q <= kept_nxt;
			end
			if (cmd.do_append) begin
				count_q <= count_q + CW'(1);
			end else if (vld_s1 && remove_q && last_s1) begin
				count_q <= kept_nxt;
			end
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.do_append || cmd.emit_full || cmd.emit_empty ||
			          cmd.emit_not_found || (vld_s1 && (!remove_q || last_s1));
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		entry_value_q <= '0;
		removed_q     <= '0;
		last_q        <= 1'b1;
		status_q      <= ST_APPENDED;
		if (cmd.emit_full) begin
			status_q <= ST_FULL;
		end else if (cmd.emit_empty) begin
			status_q <= ST_EMPTY;
		end else if (cmd.emit_not_found) begin
			status_q <= ST_NOT_FOUND;
		end else if (vld_s1 && !remove_q) begin
			status_q      <= ST_SHOWN;
			entry_value_q <= rdata_s1;
			last_q        <= last_s1;
		end else if (vld_s1 && remove_q) begin
			status_q  <= (rem_w == '0) ? ST_NOT_FOUND : ST_REMOVED;
			removed_q <= rem_w[RC_W-1:0];
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign entry_value   = entry_value_q;
	assign removed_count = removed_q;
	assign last          = last_q;

	// The count never exceeds the store.
	`OLA_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(CAPACITY))
	// Compaction writes never overtake the entry being read.
	`OLA_ASSERT_NOW(a_compact_order, vld_s1 && remove_q, kept_q <= CW'(idx_s1))
	// Shown entries come out on consecutive cycles until the last one.
	`OLA_ASSERT_NEXT(a_show_burst, done_q && !last_q, done_q)
	// The final entry of a remove walk produces a closing result.
	`OLA_ASSERT_NEXT(a_remove_close, vld_s1 && remove_q && last_s1, done_q && last_q)

endmodule

`default_nettype wire

// File: sv/ordered_list_append_remove.sv
// ----------------------------------------------------------------------------
// ordered_list_append_remove
// Ordered list of signed 32-bit values with append, show and remove actions.
// ----------------------------------------------------------------------------
// Usage:
// A transaction is accepted on a rising edge with start high and busy low;
// action selects append, show or remove, and value is the operand.
// Results appear for one cycle with done high; the receiver cannot stall,
// and last marks the final result of a transaction.
// Append, show of an empty list and remove on an empty list give one result
// in the cycle after acceptance and leave busy low.
// Show of N entries raises busy while it walks them and gives one result
// per cycle, each entry passing through the read stage and result registers.
// Remove over N entries raises busy while it walks them and gives its single
// result once the walk has read the last entry.
// The rate is set by the single read port of the entry memory, which the
// walk visits one entry per cycle. Action code 3 is taken and gives no
// result.
// Reset empties the list at once; stored values are never cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_append_remove
	import ola_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [1:0]              action,
	input  wire logic signed [VAL_W-1:0] value,
	output logic                         done,
	output logic [2:0]                   status,
	output logic signed [VAL_W-1:0]      entry_value,
	output logic [RC_W-1:0]              removed_count,
	output logic                         last
);

	cmd_t  cmd;
	stat_t stat;

	// Controller.
	ola_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath.
	ola_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.value         (value),
		.stat          (stat),
		.done          (done),
		.status        (status),
		.entry_value   (entry_value),
		.removed_count (removed_count),
		.last          (last)
	);

endmodule

`default_nettype wire
